>>> rtl/kms_pkg.sv
// Package: command codes, key map and helpers for the keypad matrix scanner.
package kms_pkg;

    localparam int unsigned NumCols = 4;
    localparam int unsigned NumRows = 4;
    localparam int unsigned NumKeys = NumCols * NumRows;
    localparam int unsigned ColW    = $clog2(NumCols);
    localparam int unsigned RowW    = $clog2(NumRows);
    localparam int unsigned KeyW    = $clog2(NumKeys);
    localparam int unsigned CodeW   = 8;

    localparam logic CMD_ADVANCE = 1'b0;
    localparam logic CMD_SAMPLE  = 1'b1;

    localparam logic [ColW-1:0] COL_RESET = ColW'(NumCols - 1);

    typedef logic [CodeW-1:0] key_code_t;

    localparam key_code_t KEY_MAP [NumKeys] = '{
        8'h44, 8'h43, 8'h42, 8'h41,   // D C B A
        8'h23, 8'h39, 8'h36, 8'h33,   // # 9 6 3
        8'h30, 8'h38, 8'h35, 8'h32,   // 0 8 5 2
        8'h2A, 8'h37, 8'h34, 8'h31    // * 7 4 1
    };

    function automatic key_code_t key_code_of(input logic [KeyW-1:0] idx);
        return KEY_MAP[idx];
    endfunction

    function automatic logic [NumCols-1:0] drive_of(input logic [ColW-1:0] col);
        logic [NumCols-1:0] d;
        d = '0;
        d[col] = 1'b1;
        return d;
    endfunction

endpackage

>>> rtl/kms_in_if.sv
// Interface: command channel into the keypad matrix scanner.
interface kms_in_if
    import kms_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                cmd;
    logic [NumRows-1:0]  row_bits;

    modport source (output valid, output cmd, output row_bits, input ready);
    modport sink   (input valid, input cmd, input row_bits, output ready);
endinterface

>>> rtl/kms_out_if.sv
// Interface: event channel out of the keypad matrix scanner.
interface kms_out_if
    import kms_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [NumCols-1:0]  column_drive;
    logic                event_valid;
    logic                pressed;
    key_code_t           key_code;
    logic                last;

    modport source (output valid, output column_drive, output event_valid,
                    output pressed, output key_code, output last, input ready);
    modport sink   (input valid, input column_drive, input event_valid,
                    input pressed, input key_code, input last, output ready);
endinterface

>>> rtl/keypad_matrix_scanner_unit.sv
// Top level: 4x4 keypad matrix scanner with pending-row queue and output register.
//
//  channel | dir | payload                                         | word accepted
//  scan    | in  | cmd, row_bits                                   | valid && ready
//  evt     | out | column_drive, event_valid, pressed, key_code, last | valid && ready
//
// An advance gives one word; a sample gives one word per changed row (0..4), issued
// one per cycle unless evt stalls, from the pending row mask to the output register.
// Flags and column update when the command word is accepted.
// Reset clears the key flags, column-active flag, pending work and output valid.
// A stall on evt holds the output word; scan is refused while earlier work
// still pends, except in the cycle its final word is issued.
module keypad_matrix_scanner_unit
    import kms_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    kms_in_if.sink        scan,
    kms_out_if.source     evt
);

    logic [ColW-1:0]     column_index_reg, column_index_next;
    logic                column_active_reg, column_active_next;
    logic [NumKeys-1:0]  key_down_reg, key_down_next;

    logic                pend_adv_reg, pend_adv_next;
    logic [NumRows-1:0]  pend_mask_reg, pend_mask_next;
    logic [NumRows-1:0]  pend_level_reg, pend_level_next;
    logic [ColW-1:0]     pend_col_reg, pend_col_next;

    logic                out_valid_reg, out_valid_next;
    logic [NumCols-1:0]  out_drive_reg, out_drive_next;
    logic                out_event_reg, out_event_next;
    logic                out_pressed_reg, out_pressed_next;
    key_code_t           out_code_reg, out_code_next;
    logic                out_last_reg, out_last_next;

    logic                busy;
    logic                out_load;
    logic                final_issue;
    logic                accept;
    logic [RowW-1:0]     row_sel;
    logic [NumRows-1:0]  mask_rest;
    logic [NumRows-1:0]  cur_flags;

    assign busy        = pend_adv_reg || (pend_mask_reg != '0);
    assign out_load    = busy && (!out_valid_reg || evt.ready);
    assign mask_rest   = pend_mask_reg & (pend_mask_reg - NumRows'(1));
    assign final_issue = out_load && (pend_adv_reg || (mask_rest == '0));
    assign scan.ready  = !busy || final_issue;
    assign accept      = scan.valid && scan.ready;
    assign cur_flags   = key_down_reg[{column_index_reg, {RowW{1'b0}}} +: NumRows];

    always_comb
    begin
        row_sel = '0;
        for (int r = NumRows - 1; r >= 0; r--)
        begin
            if (pend_mask_reg[r])
            begin
                row_sel = RowW'(r);
            end
        end
    end

    always_comb
    begin
        column_index_next  = column_index_reg;
        column_active_next = column_active_reg;
        key_down_next      = key_down_reg;
        pend_adv_next      = pend_adv_reg;
        pend_mask_next     = pend_mask_reg;
        pend_level_next    = pend_level_reg;
        pend_col_next      = pend_col_reg;

        if (out_load)
        begin
            pend_adv_next  = 1'b0;
            pend_mask_next = pend_adv_reg ? '0 : mask_rest;
        end

        if (accept)
        begin
            case (scan.cmd)
                CMD_ADVANCE:
                begin
                    column_index_next  = column_index_reg + ColW'(1);
                    column_active_next = 1'b1;
                    pend_adv_next      = 1'b1;
                    pend_mask_next     = '0;
                    pend_col_next      = column_index_reg + ColW'(1);
                end
                CMD_SAMPLE:
                begin
                    pend_adv_next = 1'b0;
                    if (column_active_reg)
                    begin
                        pend_mask_next  = scan.row_bits ^ cur_flags;
                        pend_level_next = scan.row_bits;
                        pend_col_next   = column_index_reg;
                        key_down_next[{column_index_reg, {RowW{1'b0}}} +: NumRows] =
                            scan.row_bits;
                    end
                    else
                    begin
                        pend_mask_next = '0;
                    end
                end
                default:
                begin
                    pend_adv_next = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next   = out_valid_reg && !evt.ready;
        out_drive_next   = out_drive_reg;
        out_event_next   = out_event_reg;
        out_pressed_next = out_pressed_reg;
        out_code_next    = out_code_reg;
        out_last_next    = out_last_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_drive_next = drive_of(pend_col_reg);
            if (pend_adv_reg)
            begin
                out_event_next   = 1'b0;
                out_pressed_next = 1'b0;
                out_code_next    = '0;
                out_last_next    = 1'b1;
            end
            else
            begin
                out_event_next   = 1'b1;
                out_pressed_next = pend_level_reg[row_sel];
                out_code_next    = key_code_of({pend_col_reg, row_sel});
                out_last_next    = (mask_rest == '0);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_index_reg  <= COL_RESET;
            column_active_reg <= 1'b0;
            key_down_reg      <= '0;
            pend_adv_reg      <= 1'b0;
            pend_mask_reg     <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            column_index_reg  <= column_index_next;
            column_active_reg <= column_active_next;
            key_down_reg      <= key_down_next;
            pend_adv_reg      <= pend_adv_next;
            pend_mask_reg     <= pend_mask_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_level_reg  <= pend_level_next;
        pend_col_reg    <= pend_col_next;
        out_drive_reg   <= out_drive_next;
        out_event_reg   <= out_event_next;
        out_pressed_reg <= out_pressed_next;
        out_code_reg    <= out_code_next;
        out_last_reg    <= out_last_next;
    end

    assign evt.valid        = out_valid_reg;
    assign evt.column_drive = out_drive_reg;
    assign evt.event_valid  = out_event_reg;
    assign evt.pressed      = out_pressed_reg;
    assign evt.key_code     = out_code_reg;
    assign evt.last         = out_last_reg;

    a_drive_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        evt.valid |-> $onehot(evt.column_drive))
        else $error("column drive not one-hot");

    a_adv_last: assert property (@(posedge clk) disable iff (!rst_n)
        (evt.valid && !evt.event_valid) |-> evt.last)
        else $error("advance word not marked last");

    a_more_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (evt.valid && evt.ready && !evt.last) |-> busy)
        else $error("word without last but nothing pending");

    a_adv_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && scan.cmd == CMD_ADVANCE) |=> (pend_adv_reg && column_active_reg))
        else $error("advance not queued");

    a_mask_active: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_mask_reg != '0) |-> (column_active_reg && !pend_adv_reg))
        else $error("row events pending without a driven column");

endmodule
